[rtl/mbsp_pkg.sv]
package mbsp_pkg;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] RT_FIRST    = 8'hF8;

    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] source_id;
        logic [1:0] byte_count;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } msg_t;

    // Message length in bytes, status byte included.
    function automatic logic [1:0] status_length(input logic [7:0] s);
        logic [1:0] len;
        begin
            len = LEN_TWO;
            case (s[7:4]) inside
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = LEN_THREE;
                4'hC, 4'hD:                   len = LEN_TWO;
                4'hF:
                begin
                    case (s) inside
                        8'hF6, 8'hF8, 8'hFA, 8'hFB, 8'hFC, 8'hFE, 8'hFF: len = LEN_ONE;
                        8'hF1, 8'hF3:                                    len = LEN_TWO;
                        8'hF0, 8'hF2:                                    len = LEN_THREE;
                        default:                                         len = LEN_TWO;
                    endcase
                end
                default: len = LEN_TWO;
            endcase
            return len;
        end
    endfunction

endpackage

[rtl/midi_byte_stream_parser.sv]
// Path: input register, combinational framer, output register that drives out_valid.
// Throughput: one byte per cycle; a stalled output holds the input register and then in_ready.
// Every byte, with or without a message, passes the input register and the framing update.
// Reset (rst_n, asynchronous, active low) clears running status, framing state, device_id
// and both valid flags.
module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] source_id,
    output logic [1:0] byte_count,
    output logic [7:0] first_byte,
    output logic [7:0] second_byte,
    output logic [7:0] third_byte
);

    logic [7:0] device_id_reg;
    logic       out_free;
    logic       advance;
    logic [7:0] byte_q;
    logic       res_valid;
    msg_t       res;
    msg_t       msg_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            device_id_reg <= cfg_wr_data;
        end
    end

    mbsp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .out_free (out_free),
        .advance  (advance),
        .byte_q   (byte_q)
    );

    mbsp_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_q    (byte_q),
        .device_id (device_id_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mbsp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .msg_q     (msg_q)
    );

    assign source_id   = msg_q.source_id;
    assign byte_count  = msg_q.byte_count;
    assign first_byte  = msg_q.first_byte;
    assign second_byte = msg_q.second_byte;
    assign third_byte  = msg_q.third_byte;

endmodule

[rtl/mbsp_in_stage.sv]
module mbsp_in_stage
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       out_free,
    output logic       advance,
    output logic [7:0] byte_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign advance    = valid_reg && out_free;
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign byte_q     = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
        end
    end

endmodule

[rtl/mbsp_framer.sv]
module mbsp_framer
    import mbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] byte_q,
    input  logic [7:0] device_id,
    output logic       res_valid,
    output msg_t       res
);

    logic [7:0] run_status_reg, run_status_next;
    logic [1:0] run_len_reg, run_len_next;
    logic [7:0] msg_reg [3];
    logic [7:0] msg_next [3];
    logic [1:0] fill_reg, fill_next;
    logic [1:0] exp_reg, exp_next;
    logic       in_msg_reg, in_msg_next;
    logic       in_sysex_reg, in_sysex_next;
    logic       emit;

    always_comb
    begin
        logic       is_status;
        logic       drop;
        logic [1:0] len;
        run_status_next = run_status_reg;
        run_len_next    = run_len_reg;
        msg_next        = msg_reg;
        fill_next       = fill_reg;
        exp_next        = exp_reg;
        in_msg_next     = in_msg_reg;
        in_sysex_next   = in_sysex_reg;
        is_status       = byte_q[7] && (byte_q != SYSEX_END);
        len             = status_length(byte_q);
        drop            = 1'b0;

        if (is_status)
        begin
            // Any status but end-of-sysex restarts framing; real-time leaves running status alone
            msg_next[0]   = byte_q;
            fill_next     = 2'd1;
            exp_next      = len;
            in_msg_next   = 1'b1;
            in_sysex_next = (byte_q == SYSEX_START);
            if (byte_q < RT_FIRST)
            begin
                run_status_next = byte_q;
                run_len_next    = len;
            end
        end
        else
        begin
            if (!in_msg_reg)
            begin
                if (in_sysex_reg)
                begin
                    fill_next = 2'd0;
                    exp_next  = LEN_THREE;
                end
                else if (run_len_reg < LEN_TWO)
                begin
                    drop = 1'b1;
                end
                else
                begin
                    msg_next[0] = run_status_reg;
                    fill_next   = 2'd1;
                    exp_next    = run_len_reg;
                end
            end
            if (!drop)
            begin
                in_msg_next = 1'b1;
                case (fill_next)
                    2'd0:    msg_next[0] = byte_q;
                    2'd1:    msg_next[1] = byte_q;
                    2'd2:    msg_next[2] = byte_q;
                    default: ;
                endcase
                fill_next = fill_next + 2'd1;
                if (byte_q == SYSEX_END)
                begin
                    in_sysex_next = 1'b0;
                    exp_next      = fill_next;
                end
            end
        end

        emit = in_msg_next && (exp_next == fill_next) && (exp_next != 2'd0);
        if (emit)
        begin
            in_msg_next = 1'b0;
            fill_next   = 2'd0;
        end
    end

    assign res_valid       = advance && emit;
    assign res.source_id   = device_id;
    assign res.byte_count  = exp_next;
    assign res.first_byte  = msg_next[0];
    assign res.second_byte = (exp_next >= LEN_TWO) ? msg_next[1] : 8'd0;
    assign res.third_byte  = (exp_next == LEN_THREE) ? msg_next[2] : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_status_reg <= 8'd0;
            run_len_reg    <= 2'd0;
            msg_reg[0]     <= 8'd0;
            msg_reg[1]     <= 8'd0;
            msg_reg[2]     <= 8'd0;
            fill_reg       <= 2'd0;
            exp_reg        <= 2'd0;
            in_msg_reg     <= 1'b0;
            in_sysex_reg   <= 1'b0;
        end
        else if (advance)
        begin
            run_status_reg <= run_status_next;
            run_len_reg    <= run_len_next;
            msg_reg        <= msg_next;
            fill_reg       <= fill_next;
            exp_reg        <= exp_next;
            in_msg_reg     <= in_msg_next;
            in_sysex_reg   <= in_sysex_next;
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.byte_count != 2'd0)
        else $error("emitted message with zero byte count");

    a_open_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_msg_reg |-> fill_reg < exp_reg)
        else $error("open message already holds its full length");

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_msg_reg |-> fill_reg == 2'd0)
        else $error("fill position nonzero with no open message");

endmodule

[rtl/mbsp_out_stage.sv]
module mbsp_out_stage
    import mbsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic res_valid,
    input  msg_t res,
    output logic out_free,
    output logic out_valid,
    input  logic out_ready,
    output msg_t msg_q
);

    logic valid_reg;
    logic valid_next;
    msg_t msg_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = res_valid || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign msg_q      = msg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            msg_reg <= res;
        end
    end

endmodule

[tb/midi_byte_stream_parser_tb.sv]
`timescale 1ns / 1ps

module midi_byte_stream_parser_tb;
    import mbsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 4;

    // Status nibbles of channel messages
    localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
    localparam logic [3:0] NIB_POLY_AT    = 4'hA;
    localparam logic [3:0] NIB_CTRL       = 4'hB;
    localparam logic [3:0] NIB_PROGRAM    = 4'hC;
    localparam logic [3:0] NIB_CHAN_AT    = 4'hD;
    localparam logic [3:0] NIB_PITCH_BEND = 4'hE;

    // System common and real-time bytes
    localparam logic [7:0] MTC_QFRAME = 8'hF1;
    localparam logic [7:0] SONG_POS   = 8'hF2;
    localparam logic [7:0] SONG_SEL   = 8'hF3;
    localparam logic [7:0] UNDEF_F4   = 8'hF4;
    localparam logic [7:0] UNDEF_F5   = 8'hF5;
    localparam logic [7:0] TUNE_REQ   = 8'hF6;
    localparam logic [7:0] RT_CLOCK   = 8'hF8;
    localparam logic [7:0] UNDEF_F9   = 8'hF9;
    localparam logic [7:0] RT_START   = 8'hFA;
    localparam logic [7:0] RT_CONT    = 8'hFB;
    localparam logic [7:0] RT_STOP    = 8'hFC;
    localparam logic [7:0] UNDEF_FD   = 8'hFD;
    localparam logic [7:0] RT_SENSE   = 8'hFE;
    localparam logic [7:0] RT_RESET   = 8'hFF;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] source_id;
    logic [1:0] byte_count;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;

    // Framer state mirror
    logic [7:0] device_id_q;
    logic [7:0] run_status;
    logic [1:0] run_len;
    logic [7:0] frame_buf [3];
    logic [1:0] frame_pos;
    logic [1:0] frame_len;
    logic       framing;
    logic       in_sysex;

    msg_t pending_msgs [$];
    msg_t got_msg;
    msg_t want_msg;

    int error_count     = 0;
    int sent_count      = 0;
    int idle_cycles     = 0;
    int hold_off_cycles = 0;
    bit no_idle         = 1'b0;

    midi_byte_stream_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .source_id   (source_id),
        .byte_count  (byte_count),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .third_byte  (third_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [1:0] msg_length(input logic [7:0] s);
        logic [1:0] n;
        begin
            n = LEN_TWO;
            case (s[7:4])
                NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH_BEND:
                    n = LEN_THREE;
                NIB_PROGRAM, NIB_CHAN_AT:
                    n = LEN_TWO;
                default:
                begin
                    if (s == TUNE_REQ || s == RT_CLOCK || s == RT_START || s == RT_CONT ||
                        s == RT_STOP || s == RT_SENSE || s == RT_RESET)
                        n = LEN_ONE;
                    else if (s == SYSEX_START || s == SONG_POS)
                        n = LEN_THREE;
                    else
                        n = LEN_TWO;
                end
            endcase
            return n;
        end
    endfunction

    task automatic keep_byte(input logic [7:0] b);
        begin
            if (frame_pos != 2'd3)
                frame_buf[frame_pos] = b;
            frame_pos = frame_pos + 2'd1;
        end
    endtask

    // Advance the framer by one accepted byte and queue any completed message.
    task automatic frame_byte(input logic [7:0] b);
        msg_t m;
        bit   dropped;
        begin
            dropped = 1'b0;
            if (b[7] && b != SYSEX_END)
            begin
                frame_pos = 2'd0;
                frame_len = msg_length(b);
                framing   = 1'b1;
                keep_byte(b);
                in_sysex  = (b == SYSEX_START);
                if (b < RT_FIRST)
                begin
                    run_status = b;
                    run_len    = frame_len;
                end
            end
            else
            begin
                if (!framing)
                begin
                    if (in_sysex)
                    begin
                        framing   = 1'b1;
                        frame_pos = 2'd0;
                        frame_len = LEN_THREE;
                    end
                    else if (run_len < LEN_TWO)
                        dropped = 1'b1;
                    else
                    begin
                        framing   = 1'b1;
                        frame_pos = 2'd0;
                        frame_len = run_len;
                        keep_byte(run_status);
                    end
                end
                if (!dropped)
                begin
                    keep_byte(b);
                    if (b == SYSEX_END)
                    begin
                        in_sysex  = 1'b0;
                        frame_len = frame_pos;
                    end
                end
            end
            if (!dropped && framing && frame_len == frame_pos && frame_len != 2'd0)
            begin
                m.source_id   = device_id_q;
                m.byte_count  = frame_len;
                m.first_byte  = frame_buf[0];
                m.second_byte = (frame_len >= LEN_TWO) ? frame_buf[1] : 8'h00;
                m.third_byte  = (frame_len == LEN_THREE) ? frame_buf[2] : 8'h00;
                pending_msgs.push_back(m);
                framing   = 1'b0;
                frame_pos = 2'd0;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        begin
            @(negedge clk);
            while (!no_idle && $urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_byte  <= b;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            frame_byte(b);
            sent_count++;
        end
    endtask

    // Hold the input off until every queued message has been delivered.
    task automatic wait_drained;
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_msgs.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_device_id(input logic [7:0] id);
        begin
            wait_drained();
            @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= id;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            device_id_q = id;
        end
    endtask

    task automatic send_channel_msg(input bit with_status);
        logic [7:0] status;
        int         n;
        begin
            status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            n = msg_length(status);
            if (with_status)
                send_byte(status);
            for (int i = 1; i < n; i++)
                send_byte(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic send_sysex;
        int k;
        begin
            k = $urandom_range(0, 7);
            send_byte(SYSEX_START);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                    send_byte(RT_CLOCK);
                send_byte(8'($urandom_range(0, 127)));
            end
            if ($urandom_range(0, 99) < 85)
                send_byte(SYSEX_END);
        end
    endtask

    task automatic send_system_common;
        logic [7:0] status;
        begin
            case ($urandom_range(0, 5))
                0:       status = MTC_QFRAME;
                1:       status = SONG_POS;
                2:       status = SONG_SEL;
                3:       status = UNDEF_F4;
                4:       status = UNDEF_F5;
                default: status = TUNE_REQ;
            endcase
            send_byte(status);
            for (int i = 1; i < msg_length(status); i++)
                send_byte(8'($urandom_range(0, 127)));
        end
    endtask

    task automatic send_random_traffic(input int n_items);
        int stop_at;
        int pick;
        begin
            stop_at = sent_count + n_items;
            while (sent_count < stop_at)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_channel_msg(1'b1);
                else if (pick < 60)
                    send_channel_msg(1'b0);
                else if (pick < 72)
                    send_sysex();
                else if (pick < 80)
                    send_system_common();
                else if (pick < 90)
                    send_byte(8'($urandom_range(RT_CLOCK, RT_RESET)));
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_directed_messages;
        logic [7:0] seq [$];
        begin
            set_device_id(8'hFF);
            // no running status yet: data and end-of-sysex are dropped
            seq = {8'h00, SYSEX_END,
                   8'h90, 8'h00, 8'h7F, 8'h12, 8'h34,
                   8'hC5, 8'h7F,
                   8'hE0, 8'h00, RT_CLOCK,
                   TUNE_REQ, 8'h40, SYSEX_END,
                   SYSEX_START, 8'h01, 8'h02, 8'h03, SYSEX_END,
                   8'h55, 8'h66};
            foreach (seq[i])
                send_byte(seq[i]);
            wait_drained();
        end
    endtask

    task automatic test_device_id_sweep;
        begin
            set_device_id(8'h00);
            send_random_traffic(300);
            set_device_id(8'($urandom_range(1, 254)));
            send_random_traffic(300);
            set_device_id(8'hFF);
            send_random_traffic(300);
            set_device_id(8'($urandom_range(0, 255)));
            send_random_traffic(300);
        end
    endtask

    task automatic test_back_to_back;
        begin
            no_idle = 1'b1;
            send_random_traffic(200);
            wait_drained();
            no_idle = 1'b0;
        end
    endtask

    task automatic test_output_hold_off;
        begin
            hold_off_cycles = 400;
            send_random_traffic(80);
            wait_drained();
            send_random_traffic(40);
            wait_drained();
        end
    endtask

    // Drive out_ready; while a hold-off request is pending it stays low and the request counts down.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_msg = '{source_id, byte_count, first_byte, second_byte, third_byte};
            if (pending_msgs.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected message, actual id=%h n=%0d bytes=%h %h %h",
                         $time, got_msg.source_id, got_msg.byte_count,
                         got_msg.first_byte, got_msg.second_byte, got_msg.third_byte);
            end
            else
            begin
                want_msg = pending_msgs.pop_front();
                if (got_msg.source_id   !== want_msg.source_id   ||
                    got_msg.byte_count  !== want_msg.byte_count  ||
                    got_msg.first_byte  !== want_msg.first_byte  ||
                    got_msg.second_byte !== want_msg.second_byte ||
                    got_msg.third_byte  !== want_msg.third_byte)
                begin
                    error_count++;
                    $display({"%0t: mismatch, expected id=%h n=%0d bytes=%h %h %h,",
                              " actual id=%h n=%0d bytes=%h %h %h"},
                             $time, want_msg.source_id, want_msg.byte_count,
                             want_msg.first_byte, want_msg.second_byte, want_msg.third_byte,
                             got_msg.source_id, got_msg.byte_count,
                             got_msg.first_byte, got_msg.second_byte, got_msg.third_byte);
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        device_id_q = 8'h00;
        run_status  = 8'h00;
        run_len     = 2'd0;
        frame_buf   = '{8'h00, 8'h00, 8'h00};
        frame_pos   = 2'd0;
        frame_len   = 2'd0;
        framing     = 1'b0;
        in_sysex    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_messages();
        test_device_id_sweep();
        test_back_to_back();
        test_output_hold_off();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
